### hdl/pdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdr_pkg;

    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int TRIG_BITS         = 30;

    // CORDIC datapath width (angle, x, y)
    localparam int CW = 34;

    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    // Payload carried alongside the CORDIC
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] nh;
        logic               ovf;
        logic               neg;
    } t_side;

    // Arctangent of 2^-i in Q30 radians
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        unique case (idx)
            0:       v = 30'd843314857;
            1:       v = 30'd497837829;
            2:       v = 30'd263043837;
            3:       v = 30'd133525159;
            4:       v = 30'd67021687;
            5:       v = 30'd33543516;
            6:       v = 30'd16775851;
            7:       v = 30'd8388437;
            8:       v = 30'd4194283;
            9:       v = 30'd2097149;
            10:      v = 30'd1048576;
            11:      v = 30'd524288;
            12:      v = 30'd262144;
            13:      v = 30'd131072;
            14:      v = 30'd65536;
            15:      v = 30'd32768;
            16:      v = 30'd16384;
            17:      v = 30'd8192;
            18:      v = 30'd4096;
            19:      v = 30'd2048;
            20:      v = 30'd1024;
            21:      v = 30'd512;
            22:      v = 30'd256;
            23:      v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Clamp to signed 32 bits; bit 32 flags saturation
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/pdr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pdr_front import pdr_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_rdy,
    input  wire logic signed [31:0]   i_px,
    input  wire logic signed [31:0]   i_py,
    input  wire logic signed [31:0]   i_ph,
    input  wire logic signed [31:0]   i_vf,
    input  wire logic signed [31:0]   i_vl,
    input  wire logic signed [31:0]   i_wr,
    input  wire logic        [31:0]   i_dt,
    output logic                      o_valid,
    input  wire logic                 i_rdy,
    output logic signed [CW-1:0]      o_z,
    output t_side                     o_side
);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic r1_v, r2_v, r3_v;
    logic rdy1, rdy2, rdy3;

    logic signed [63:0] r1_pf, r1_pl, r1_pw, r1_pt;
    logic signed [31:0] r1_px, r1_py, r1_ph;

    logic signed [31:0] r2_dx, r2_dy, r2_p, r2_px, r2_py, r2_ph;
    logic signed [63:0] r2_dth;
    logic               r2_ovf, r2_neg;

    logic signed [63:0] r3_zp;
    t_side              r3_side;

    logic [32:0]        w_sdx, w_sdy, w_snh;
    logic signed [31:0] w_p;
    logic signed [32:0] w_pe, w_pf;
    logic               w_neg;

    assign rdy3  = !r3_v || i_rdy;
    assign rdy2  = !r2_v || rdy3;
    assign rdy1  = !r1_v || rdy2;
    assign o_rdy = rdy1;

    // Round interval products, fold the phase into a half turn, sum heading
    always_comb begin
        w_sdx = sat32((r1_pf + HALF) >>> FRAC_BITS);
        w_sdy = sat32((r1_pl + HALF) >>> FRAC_BITS);
        w_p   = $signed(r1_pt[FRAC_BITS+31:FRAC_BITS]);
        w_pe  = 33'(w_p);
        w_neg = 1'b0;
        w_pf  = w_pe;
        if (w_pe > 33'sh0_4000_0000) begin
            w_pf  = w_pe - 33'sh0_8000_0000;
            w_neg = 1'b1;
        end else if (w_pe < -33'sh0_4000_0000) begin
            w_pf  = w_pe + 33'sh0_8000_0000;
            w_neg = 1'b1;
        end
        w_snh = sat32(64'(r2_ph) + r2_dth);
    end

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_pf <= $signed(i_vf) * $signed({1'b0, i_dt});
            r1_pl <= $signed(i_vl) * $signed({1'b0, i_dt});
            r1_pw <= $signed(i_wr) * $signed({1'b0, i_dt});
            r1_pt <= $signed(i_ph) * $signed({2'b00, INV_TWO_PI_Q32});
            r1_px <= i_px;
            r1_py <= i_py;
            r1_ph <= i_ph;
        end
        if (rdy2) begin
            r2_dx  <= $signed(w_sdx[31:0]);
            r2_dy  <= $signed(w_sdy[31:0]);
            r2_ovf <= w_sdx[32] | w_sdy[32];
            r2_dth <= (r1_pw + HALF) >>> FRAC_BITS;
            r2_p   <= w_pf[31:0];
            r2_neg <= w_neg;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_ph  <= r1_ph;
        end
        if (rdy3) begin
            r3_zp       <= $signed(r2_p) * $signed({1'b0, HALF_PI_Q30});
            r3_side.px  <= r2_px;
            r3_side.py  <= r2_py;
            r3_side.dx  <= r2_dx;
            r3_side.dy  <= r2_dy;
            r3_side.nh  <= $signed(w_snh[31:0]);
            r3_side.ovf <= r2_ovf | w_snh[32];
            r3_side.neg <= r2_neg;
        end
    end

    assign o_valid = r3_v;
    assign o_z     = $signed(r3_zp[TRIG_BITS+CW-1:TRIG_BITS]);
    assign o_side  = r3_side;

endmodule
`default_nettype wire

### hdl/pdr_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module pdr_cordic import pdr_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_rdy,
    input  wire logic signed [CW-1:0] i_z,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_rdy,
    output logic signed [CW-1:0]      o_cos,
    output logic signed [CW-1:0]      o_sin,
    output t_side                     o_side
);
    localparam int N = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    logic signed [CW-1:0] w_x [0:N];
    logic signed [CW-1:0] w_y [0:N];
    logic signed [CW-1:0] w_z [0:N];
    t_side                w_s [0:N];
    logic                 w_v [0:N];
    logic                 w_r [0:N];

    assign w_x[0] = $signed({{(CW-30){1'b0}}, CORDIC_GAIN_Q30});
    assign w_y[0] = '0;
    assign w_z[0] = i_z;
    assign w_s[0] = i_side;
    assign w_v[0] = i_valid;
    assign w_r[N] = i_rdy;
    assign o_rdy  = w_r[0];

    // One micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = $signed({{(CW-30){1'b0}}, atan_q30(i)});
        logic                 r_v;
        logic signed [CW-1:0] r_x, r_y, r_z;
        t_side                r_s;

        assign w_r[i] = !r_v || w_r[i+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_r[i]) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_r[i]) begin
                if (w_z[i] >= 0) begin
                    r_x <= w_x[i] - (w_y[i] >>> i);
                    r_y <= w_y[i] + (w_x[i] >>> i);
                    r_z <= w_z[i] - ATAN;
                end else begin
                    r_x <= w_x[i] + (w_y[i] >>> i);
                    r_y <= w_y[i] - (w_x[i] >>> i);
                    r_z <= w_z[i] + ATAN;
                end
                r_s <= w_s[i];
            end
        end

        assign w_v[i+1] = r_v;
        assign w_x[i+1] = r_x;
        assign w_y[i+1] = r_y;
        assign w_z[i+1] = r_z;
        assign w_s[i+1] = r_s;
    end

    assign o_valid = w_v[N];
    assign o_cos   = w_x[N];
    assign o_sin   = w_y[N];
    assign o_side  = w_s[N];

endmodule
`default_nettype wire

### hdl/pdr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pdr_back import pdr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_rdy,
    input  wire logic signed [CW-1:0] i_cos,
    input  wire logic signed [CW-1:0] i_sin,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [31:0]        o_next_x,
    output logic signed [31:0]        o_next_y,
    output logic signed [31:0]        o_next_heading,
    output logic                      o_overflow
);
    localparam int PW = CW + 32;
    localparam int SW = PW + 1 - TRIG_BITS;
    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (TRIG_BITS - 1);

    logic r1_v, r2_v, r3_v;
    logic rdy1, rdy2, rdy3;

    logic signed [CW-1:0] w_c, w_s;
    logic signed [PW-1:0] r1_dxc, r1_dys, r1_dyc, r1_dxs;
    logic signed [31:0]   r1_px, r1_py, r1_nh, r2_px, r2_py, r2_nh;
    logic                 r1_ovf, r2_ovf;
    logic signed [PW:0]   w_sx, w_sy;
    logic signed [SW-1:0] r2_sx, r2_sy;
    logic [32:0]          w_nx, w_ny;
    logic signed [31:0]   r3_x, r3_y, r3_h;
    logic                 r3_ovf;

    assign rdy3  = !r3_v || !i_stall;
    assign rdy2  = !r2_v || rdy3;
    assign rdy1  = !r1_v || rdy2;
    assign o_rdy = rdy1;

    // Undo the half-turn fold, then sum, round and saturate
    always_comb begin
        w_c  = i_side.neg ? -i_cos : i_cos;
        w_s  = i_side.neg ? -i_sin : i_sin;
        w_sx = (PW+1)'(r1_dxc) - (PW+1)'(r1_dys) + HALF;
        w_sy = (PW+1)'(r1_dyc) + (PW+1)'(r1_dxs) + HALF;
        w_nx = sat32(64'(r2_px) + 64'(r2_sx));
        w_ny = sat32(64'(r2_py) + 64'(r2_sy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_dxc <= PW'(i_side.dx) * PW'(w_c);
            r1_dys <= PW'(i_side.dy) * PW'(w_s);
            r1_dyc <= PW'(i_side.dy) * PW'(w_c);
            r1_dxs <= PW'(i_side.dx) * PW'(w_s);
            r1_px  <= i_side.px;
            r1_py  <= i_side.py;
            r1_nh  <= i_side.nh;
            r1_ovf <= i_side.ovf;
        end
        if (rdy2) begin
            r2_sx  <= w_sx[PW:TRIG_BITS];
            r2_sy  <= w_sy[PW:TRIG_BITS];
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_nh  <= r1_nh;
            r2_ovf <= r1_ovf;
        end
        if (rdy3) begin
            r3_x   <= $signed(w_nx[31:0]);
            r3_y   <= $signed(w_ny[31:0]);
            r3_h   <= r2_nh;
            r3_ovf <= r2_ovf | w_nx[32] | w_ny[32];
        end
    end

    assign o_valid        = r3_v;
    assign o_next_x       = r3_x;
    assign o_next_y       = r3_y;
    assign o_next_heading = r3_h;
    assign o_overflow     = r3_ovf;

endmodule
`default_nettype wire

### hdl/pose_dead_reckoning.sv
`timescale 1ns / 1ps
`default_nettype none
// Planar dead reckoning: predicts x, y and heading after one interval from a
// body-frame velocity, with heading sine and cosine from a pipelined CORDIC.
// Fully pipelined: one item per cycle unless stalled; three front stages for
// products, rounding and phase reduction, one stage per CORDIC iteration,
// three back stages for rotation and saturation.
// Each stage holds under stall independently, so bubbles are squeezed out.
module pose_dead_reckoning import pdr_pkg::*; #(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_pose_x,
    input  wire logic signed [31:0] i_pose_y,
    input  wire logic signed [31:0] i_pose_heading,
    input  wire logic signed [31:0] i_speed_forward,
    input  wire logic signed [31:0] i_speed_lateral,
    input  wire logic signed [31:0] i_turn_rate,
    input  wire logic        [31:0] i_time_step,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_next_x,
    output logic signed [31:0]      o_next_y,
    output logic signed [31:0]      o_next_heading,
    output logic                    o_overflow
);
    logic                 w_in_rdy, w_f_v, w_f_rdy, w_c_v, w_c_rdy;
    logic signed [CW-1:0] w_z, w_cos, w_sin;
    t_side                w_f_side, w_c_side;

    assign o_stall = !w_in_rdy;

    pdr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_rdy   (w_in_rdy),
        .i_px    (i_pose_x),
        .i_py    (i_pose_y),
        .i_ph    (i_pose_heading),
        .i_vf    (i_speed_forward),
        .i_vl    (i_speed_lateral),
        .i_wr    (i_turn_rate),
        .i_dt    (i_time_step),
        .o_valid (w_f_v),
        .i_rdy   (w_f_rdy),
        .o_z     (w_z),
        .o_side  (w_f_side)
    );

    pdr_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_v),
        .o_rdy   (w_f_rdy),
        .i_z     (w_z),
        .i_side  (w_f_side),
        .o_valid (w_c_v),
        .i_rdy   (w_c_rdy),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_side  (w_c_side)
    );

    pdr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_c_v),
        .o_rdy          (w_c_rdy),
        .i_cos          (w_cos),
        .i_sin          (w_sin),
        .i_side         (w_c_side),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_x       (o_next_x),
        .o_next_y       (o_next_y),
        .o_next_heading (o_next_heading),
        .o_overflow     (o_overflow)
    );

endmodule
`default_nettype wire

### tb/pose_dead_reckoning_tb.sv
`timescale 1ns / 1ps
module pose_dead_reckoning_tb;
    import pdr_pkg::*;

    localparam int F        = DEF_FRAC_BITS;
    localparam int NSTAGE   = DEF_CORDIC_STAGES;
    localparam int LATENCY  = 6 + ((NSTAGE < 24) ? NSTAGE : 24);
    localparam int MAX_CYC  = 2000000;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nh;
        logic               ovf;
    } pose_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_pose_x = '0;
    logic signed [31:0] i_pose_y = '0;
    logic signed [31:0] i_pose_heading = '0;
    logic signed [31:0] i_speed_forward = '0;
    logic signed [31:0] i_speed_lateral = '0;
    logic signed [31:0] i_turn_rate = '0;
    logic        [31:0] i_time_step = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_next_x;
    logic signed [31:0] o_next_y;
    logic signed [31:0] o_next_heading;
    logic               o_overflow;

    pose_t pending_poses[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    items_sent = 0;
    int    cycles = 0;
    int    gap_pct = 0;
    int    stall_pct = 0;

    pose_dead_reckoning dut (.*);

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Floor shift of a signed value
    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rshift(longint v, int n);
        return fshift(v + (longint'(1) <<< (n - 1)), n);
    endfunction

    function automatic longint clamp32(longint v, ref logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Predict the pose after one interval
    function automatic pose_t predict_pose(longint px, longint py, longint ph,
                                           longint vf, longint vl, longint wr,
                                           longint dt);
        pose_t  r;
        logic   ovf;
        longint dx, dy, dth, prod, p, z, x, y, nx, ny;
        logic [31:0] turns;
        logic   neg;
        ovf = 1'b0;
        neg = 1'b0;
        dx  = clamp32(rshift(vf * dt, F), ovf);
        dy  = clamp32(rshift(vl * dt, F), ovf);
        dth = rshift(wr * dt, F);
        // reduce heading to turns, fold into +-1/4 turn
        prod  = ph * longint'(INV_TWO_PI_Q32);
        turns = prod[F +: 32];
        p     = longint'($signed(turns));
        if (p > (longint'(1) <<< 30)) begin
            p -= longint'(1) <<< 31;
            neg = 1'b1;
        end else if (p < -(longint'(1) <<< 30)) begin
            p += longint'(1) <<< 31;
            neg = 1'b1;
        end
        z = fshift(p * longint'(HALF_PI_Q30), 30);
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < NSTAGE && i < ATAN_COUNT; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                ny = y + fshift(x, i);
                z -= longint'(atan_q30(i));
            end else begin
                nx = x + fshift(y, i);
                ny = y - fshift(x, i);
                z += longint'(atan_q30(i));
            end
            x = nx;
            y = ny;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        r.nx  = 32'(clamp32(px + rshift(dx * x - dy * y, TRIG_BITS), ovf));
        r.ny  = 32'(clamp32(py + rshift(dy * x + dx * y, TRIG_BITS), ovf));
        r.nh  = 32'(clamp32(ph + dth, ovf));
        r.ovf = ovf;
        return r;
    endfunction

    // Send one item, holding it until accepted; valid stays high afterwards
    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] ph,
                             logic [31:0] vf, logic [31:0] vl, logic [31:0] wr,
                             logic [31:0] dt);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_pose_x        <= px;
        i_pose_y        <= py;
        i_pose_heading  <= ph;
        i_speed_forward <= vf;
        i_speed_lateral <= vl;
        i_turn_rate     <= wr;
        i_time_step     <= dt;
        pending_poses.push_back(predict_pose($signed(px), $signed(py), $signed(ph),
            $signed(vf), $signed(vl), $signed(wr), longint'({32'd0, dt})));
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Random stall on the result side
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        pose_t e;
        cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = pending_poses.pop_front();
                if (o_next_x !== e.nx || o_next_y !== e.ny || o_next_heading !== e.nh
                        || o_overflow !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d h=%0d ovf=%0b",
                                 e.nx, e.ny, e.nh, e.ovf,
                                 " got x=%0d y=%0d h=%0d ovf=%0b",
                                 o_next_x, o_next_y, o_next_heading, o_overflow);
                end
            end
        end
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("** pose_dead_reckoning: FAILED **");
            $finish;
        end
    end

    // Drop valid and wait until every expected result has come
    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_poses.size() != 0);
    endtask

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Field extremes, headings around the fold points, saturation
    task automatic test_directed;
        logic [31:0] hd[6];
        hd = '{32'h0001_921F, 32'hFFFE_6DE1, 32'h0003_243F, 32'hFFFC_DBC1,
               32'h0000_C90F, 32'h0004_B65F};
        send_pose(0, 0, 0, 0, 0, 0, 0);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pose(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_pose(32'h7FFF_0000, 0, 0, 32'h0010_0000, 0, 0, 32'h0010_0000);
        send_pose(0, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFF0_0000,
                  32'hFFF0_0000, 32'h0010_0000);
        foreach (hd[i])
            send_pose($urandom(), $urandom(), hd[i], 32'h0002_0000, 32'hFFFF_0000,
                      $urandom(), 32'h0000_1000);
        send_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    // Half realistic motion, the rest fully random or edge-valued fields
    task automatic test_random(int n);
        logic [31:0] f[7];
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: foreach (f[i]) f[i] = $urandom();
                1: foreach (f[i]) f[i] = pick_edge();
                default: begin
                    f[0] = $signed($urandom()) >>> $urandom_range(8);
                    f[1] = $signed($urandom()) >>> $urandom_range(8);
                    f[2] = $signed($urandom()) >>> $urandom_range(4, 14);
                    f[3] = $signed($urandom()) >>> $urandom_range(8, 14);
                    f[4] = $signed($urandom()) >>> $urandom_range(10, 16);
                    f[5] = $signed($urandom()) >>> $urandom_range(10, 14);
                    f[6] = $urandom() >> $urandom_range(8, 16);
                end
            endcase
            send_pose(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
        end
    endtask

    // Hold off the sender until the pipe is empty, then resume
    task automatic test_drain_pause;
        test_random(40);
        drain();
        test_random(40);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(350);
        gap_pct = 50;
        test_random(350);
        gap_pct = 0;
        stall_pct = 50;
        test_random(350);
        gap_pct = 32;
        stall_pct = 32;
        test_random(350);
        gap_pct = 0;
        stall_pct = 0;
        test_drain_pause();
        stall_pct = 20;
        test_random(300);
        stall_pct = 0;
        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Sent %0d poses, checked %0d predictions under gaps and stalls.",
                 items_sent, results_seen);
        if (mismatches == 0 && pending_poses.size() == 0) begin
            $display("** pose_dead_reckoning: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** pose_dead_reckoning: FAILED **");
        end
        $finish;
    end
endmodule
